// ----- sv/rrs_pkg.sv -----
// Shared constants, types and square-root step for the rounded-rectangle span generator.
`timescale 1ns / 1ps

package rrs_pkg;

  // Geometry and stroke bounds
  localparam int COORD_WIDTH  = 10;
  localparam int MAX_STROKE   = 15;
  localparam int STROKE_REG_W = 4;
  localparam int STROKE_CNT_W = $clog2(MAX_STROKE + 1);
  localparam int CFG_INDEX_W  = 3;

  // Radicand holds rad*rad with rad <= 2^(COORD_WIDTH-1)
  localparam int SQ_W       = 2 * COORD_WIDTH - 1;
  localparam int ACC_W      = 2 * COORD_WIDTH;
  localparam int LE_W       = COORD_WIDTH + 2;
  localparam int ISQ_STAGES = (COORD_WIDTH + 1) / 2;

  // Register indexes on the write port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CORNER_X_A    = 3'd0,
    REG_CORNER_X_B    = 3'd1,
    REG_CORNER_Y_A    = 3'd2,
    REG_CORNER_Y_B    = 3'd3,
    REG_CORNER_RADIUS = 3'd4,
    REG_FILL_MODE     = 3'd5,
    REG_STROKE_WIDTH  = 3'd6
  } rrs_reg_t;

  // Shape values derived from the registers
  typedef struct packed {
    logic [COORD_WIDTH-1:0]  l;
    logic [COORD_WIDTH-1:0]  r;
    logic [COORD_WIDTH-1:0]  t;
    logic [COORD_WIDTH:0]    h;
    logic [COORD_WIDTH-1:0]  rad;
    logic [STROKE_CNT_W-1:0] s_eff;
    logic                    fill;
    logic                    thin;
    logic [SQ_W-1:0]         rad_sq;
    logic signed [LE_W-1:0]  lower_edge;
    logic [STROKE_CNT_W-1:0] count_last;
  } rrs_cfg_t;

  // Per-row data that rides along the pipeline
  typedef struct packed {
    logic [COORD_WIDTH-1:0] y;
    logic                   corner;
    logic                   full;
  } rrs_row_t;

  // Square-root working pair
  typedef struct packed {
    logic [SQ_W-1:0]  rem;
    logic [ACC_W-1:0] acc;
  } rrs_sq_t;

  // Probe of iteration i of the bit-by-bit root
  function automatic logic [ACC_W-1:0] probe_at(int i);
    probe_at = ACC_W'(1) << (2 * COORD_WIDTH - 2 - 2 * i);
  endfunction

  // One iteration of the bit-by-bit root
  function automatic rrs_sq_t isqrt_step(rrs_sq_t cur, logic [ACC_W-1:0] probe);
    logic [ACC_W:0] trial;
    rrs_sq_t        res;
    trial = {1'b0, cur.acc} + {1'b0, probe};
    if ({{(ACC_W + 1 - SQ_W){1'b0}}, cur.rem} >= trial) begin
      res.rem = cur.rem - trial[SQ_W-1:0];
      res.acc = (cur.acc >> 1) + probe;
    end else begin
      res.rem = cur.rem;
      res.acc = cur.acc >> 1;
    end
    return res;
  endfunction

endpackage

// ----- sv/rounded_rect_span_generator.sv -----
// Top level of the rounded-rectangle span generator.
//
//   channel   ports                                         handshake
//   config    cfg_we, cfg_index, cfg_data                   write at edge with cfg_we
//   row in    start, busy, row_offset                       start && !busy
//   span out  strobe, span_y, span_x_left, span_x_right,    strobe, one cycle each
//             last_span
//
// One row is accepted per cycle while rows give a single span; a row that
// gives n spans (two for an outline pixel pair, s or 2*s for a thick stroke)
// holds the span sequencer until its last span, and busy stays high for all
// but the last of them.
// The first span of a row leaves once the accepted row has passed these registers:
// intake, corner offset, radicand, five root stages, span sequencer.
// Rows outside the height take one pipeline slot and give no span.
// Reset is synchronous; it empties the pipeline and loads the register
// reset values, and a row may be taken in the next cycle.
`timescale 1ns / 1ps

module rounded_rect_span_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rrs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rrs_pkg::COORD_WIDTH-1:0]   cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic [rrs_pkg::COORD_WIDTH-1:0]   row_offset,
  output logic                              strobe,
  output logic [rrs_pkg::COORD_WIDTH-1:0]   span_y,
  output logic [rrs_pkg::COORD_WIDTH-1:0]   span_x_left,
  output logic [rrs_pkg::COORD_WIDTH-1:0]   span_x_right,
  output logic                              last_span
);

  rrs_pkg::rrs_cfg_t              cfg;
  logic                           adv;
  logic                           fr_valid;
  logic [rrs_pkg::SQ_W-1:0]       fr_rem;
  rrs_pkg::rrs_row_t              fr_row;
  logic                           sq_valid;
  logic [rrs_pkg::COORD_WIDTH-1:0] sq_root;
  rrs_pkg::rrs_row_t              sq_row;

  // Registers and derived geometry
  rrs_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Row intake through radicand
  rrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .start      (start),
    .row_offset (row_offset),
    .cfg        (cfg),
    .out_valid  (fr_valid),
    .out_rem    (fr_rem),
    .out_row    (fr_row)
  );

  // Corner root
  rrs_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (fr_valid),
    .in_rem    (fr_rem),
    .in_row    (fr_row),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_row   (sq_row)
  );

  // Span sequencer and output ports
  rrs_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (sq_valid),
    .in_root      (sq_root),
    .in_row       (sq_row),
    .adv          (adv),
    .busy         (busy),
    .strobe       (strobe),
    .span_y       (span_y),
    .span_x_left  (span_x_left),
    .span_x_right (span_x_right),
    .last_span    (last_span)
  );

endmodule

// ----- sv/rrs_config.sv -----
// Configuration registers and the derived rectangle geometry.
`timescale 1ns / 1ps

module rrs_config (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rrs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rrs_pkg::COORD_WIDTH-1:0]     cfg_data,
  output rrs_pkg::rrs_cfg_t                   cfg
);

  localparam int CW = rrs_pkg::COORD_WIDTH;
  localparam int SW = rrs_pkg::STROKE_CNT_W;

  logic [CW-1:0]                     corner_x_a;
  logic [CW-1:0]                     corner_x_b;
  logic [CW-1:0]                     corner_y_a;
  logic [CW-1:0]                     corner_y_b;
  logic [CW-1:0]                     corner_radius;
  logic                              fill_mode;
  logic [rrs_pkg::STROKE_REG_W-1:0]  stroke_width;

  logic [CW-1:0]   l_next, r_next, t_next, b_next, rad_next;
  logic [CW:0]     w_next, h_next, short_side;
  logic [CW-1:0]   half;
  logic [SW-1:0]   s_next;
  logic [2*CW-1:0] rad_sq_full;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_x_a    <= '0;
      corner_x_b    <= '0;
      corner_y_a    <= '0;
      corner_y_b    <= '0;
      corner_radius <= '0;
      fill_mode     <= 1'b0;
      stroke_width  <= rrs_pkg::STROKE_REG_W'(1);
    end else if (cfg_we) begin
      case (rrs_pkg::rrs_reg_t'(cfg_index))
        rrs_pkg::REG_CORNER_X_A:    corner_x_a    <= cfg_data;
        rrs_pkg::REG_CORNER_X_B:    corner_x_b    <= cfg_data;
        rrs_pkg::REG_CORNER_Y_A:    corner_y_a    <= cfg_data;
        rrs_pkg::REG_CORNER_Y_B:    corner_y_b    <= cfg_data;
        rrs_pkg::REG_CORNER_RADIUS: corner_radius <= cfg_data;
        rrs_pkg::REG_FILL_MODE:     fill_mode     <= cfg_data[0];
        rrs_pkg::REG_STROKE_WIDTH:  stroke_width  <= cfg_data[rrs_pkg::STROKE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Order the corners, size the box and clamp the radius and the stroke width
  always_comb begin
    l_next     = (corner_x_a < corner_x_b) ? corner_x_a : corner_x_b;
    r_next     = (corner_x_a < corner_x_b) ? corner_x_b : corner_x_a;
    t_next     = (corner_y_a < corner_y_b) ? corner_y_a : corner_y_b;
    b_next     = (corner_y_a < corner_y_b) ? corner_y_b : corner_y_a;
    w_next     = {1'b0, r_next} - {1'b0, l_next} + (CW + 1)'(1);
    h_next     = {1'b0, b_next} - {1'b0, t_next} + (CW + 1)'(1);
    short_side = (w_next < h_next) ? w_next : h_next;
    half       = short_side[CW:1];
    rad_next   = (corner_radius < half) ? corner_radius : half;
    s_next     = (int'(stroke_width) < rrs_pkg::MAX_STROKE) ? SW'(stroke_width)
                                                            : SW'(rrs_pkg::MAX_STROKE);
  end

  assign rad_sq_full = cfg.rad * cfg.rad;

  // First level from the registers, second level built on the first
  always_ff @(posedge clk) begin
    cfg.l          <= l_next;
    cfg.r          <= r_next;
    cfg.t          <= t_next;
    cfg.h          <= h_next;
    cfg.rad        <= rad_next;
    cfg.s_eff      <= s_next;
    cfg.fill       <= fill_mode;
    cfg.thin       <= (stroke_width <= rrs_pkg::STROKE_REG_W'(1));
    cfg.rad_sq     <= rad_sq_full[rrs_pkg::SQ_W-1:0];
    cfg.lower_edge <= $signed(rrs_pkg::LE_W'(cfg.h) - rrs_pkg::LE_W'(1)
                              - rrs_pkg::LE_W'(cfg.s_eff));
    cfg.count_last <= (cfg.fill || cfg.thin) ? '0 : cfg.s_eff - SW'(1);
  end

endmodule

// ----- sv/rrs_front.sv -----
// Row intake, range check, corner offset and radicand stages.
`timescale 1ns / 1ps

module rrs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              start,
  input  logic [rrs_pkg::COORD_WIDTH-1:0]   row_offset,
  input  rrs_pkg::rrs_cfg_t                 cfg,
  output logic                              out_valid,
  output logic [rrs_pkg::SQ_W-1:0]          out_rem,
  output rrs_pkg::rrs_row_t                 out_row
);

  localparam int CW = rrs_pkg::COORD_WIDTH;

  // Stage 0: captured request
  logic          v0;
  logic [CW-1:0] row0;

  // Stage 1: row in range, corner offset
  logic          v1;
  logic [CW-1:0] row1;
  logic [CW-1:0] y1;
  logic [CW-1:0] dy1;
  logic          corner1;

  logic          in_range, corner_top, corner_bot;
  logic [CW:0]   h_m_r, bot_dy;
  logic [CW-1:0] dy_next;

  logic [2*CW-1:0] dy_sq;
  logic            row_last, band, full_next;

  // Take a request whenever the pipeline moves
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0   <= start;
      row0 <= row_offset;
    end
  end

  // Find the corner zone and its vertical offset
  always_comb begin
    in_range   = {1'b0, row0} < cfg.h;
    corner_top = row0 < cfg.rad;
    h_m_r      = cfg.h - {1'b0, cfg.rad};
    corner_bot = {1'b0, row0} >= h_m_r;
    bot_dy     = {1'b0, row0} - h_m_r + (CW + 1)'(1);
    if (corner_top) begin
      dy_next = cfg.rad - row0;
    end else if (corner_bot) begin
      dy_next = bot_dy[CW-1:0];
    end else begin
      dy_next = '0;
    end
  end

  // Drop rows outside the height
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1      <= v0 && in_range;
      row1    <= row0;
      y1      <= cfg.t + row0;
      dy1     <= dy_next;
      corner1 <= corner_top || corner_bot;
    end
  end

  // Radicand and span shape of the row
  always_comb begin
    dy_sq    = dy1 * dy1;
    row_last = {1'b0, row1} == (cfg.h - (CW + 1)'(1));
    band     = (row1 <= CW'(cfg.s_eff)) || ($signed({2'b00, row1}) >= cfg.lower_edge);
    if (cfg.fill) begin
      full_next = 1'b1;
    end else if (cfg.thin) begin
      full_next = (row1 == '0) || row_last;
    end else begin
      full_next = band;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid      <= v1;
      out_rem        <= cfg.rad_sq - dy_sq[rrs_pkg::SQ_W-1:0];
      out_row.y      <= y1;
      out_row.corner <= corner1;
      out_row.full   <= full_next;
    end
  end

endmodule

// ----- sv/rrs_isqrt.sv -----
// Pipelined bit-by-bit integer square root, two result bits per stage.
`timescale 1ns / 1ps

module rrs_isqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic [rrs_pkg::SQ_W-1:0]          in_rem,
  input  rrs_pkg::rrs_row_t                 in_row,
  output logic                              out_valid,
  output logic [rrs_pkg::COORD_WIDTH-1:0]   out_root,
  output rrs_pkg::rrs_row_t                 out_row
);

  localparam int NS   = rrs_pkg::ISQ_STAGES;
  localparam int CW   = rrs_pkg::COORD_WIDTH;
  localparam int LAST = NS - 1;

  logic              vld [NS];
  rrs_pkg::rrs_sq_t  st  [NS];
  rrs_pkg::rrs_row_t rw  [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic              src_v;
    rrs_pkg::rrs_sq_t  src_st;
    rrs_pkg::rrs_row_t src_row;
    rrs_pkg::rrs_sq_t  mid_st;
    rrs_pkg::rrs_sq_t  nxt_st;

    // Select the stage input
    if (j == 0) begin : g_head
      assign src_v   = in_valid;
      assign src_st  = '{rem: in_rem, acc: '0};
      assign src_row = in_row;
    end else begin : g_body
      assign src_v   = vld[j-1];
      assign src_st  = st[j-1];
      assign src_row = rw[j-1];
    end

    // Two root iterations, the second only while bits remain
    assign mid_st = rrs_pkg::isqrt_step(src_st, rrs_pkg::probe_at(2 * j));
    if (2 * j + 1 < CW) begin : g_two
      assign nxt_st = rrs_pkg::isqrt_step(mid_st, rrs_pkg::probe_at(2 * j + 1));
    end else begin : g_one
      assign nxt_st = mid_st;
    end

    // Advance the stage register
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (adv) begin
        vld[j] <= src_v;
        st[j]  <= nxt_st;
        rw[j]  <= src_row;
      end
    end
  end

  assign out_valid = vld[LAST];
  assign out_root  = st[LAST].acc[CW-1:0];
  assign out_row   = rw[LAST];

  // Remainder of a floor root never exceeds twice the root
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    vld[LAST] |-> ({{(rrs_pkg::ACC_W - rrs_pkg::SQ_W){1'b0}}, st[LAST].rem}
                   <= (st[LAST].acc << 1)))
    else $error("square root remainder out of bound");

endmodule

// ----- sv/rrs_emitter.sv -----
// Span sequencer: turns one row into its spans, one span per cycle.
`timescale 1ns / 1ps

module rrs_emitter (
  input  logic                              clk,
  input  logic                              rst,
  input  rrs_pkg::rrs_cfg_t                 cfg,
  input  logic                              in_valid,
  input  logic [rrs_pkg::COORD_WIDTH-1:0]   in_root,
  input  rrs_pkg::rrs_row_t                 in_row,
  output logic                              adv,
  output logic                              busy,
  output logic                              strobe,
  output logic [rrs_pkg::COORD_WIDTH-1:0]   span_y,
  output logic [rrs_pkg::COORD_WIDTH-1:0]   span_x_left,
  output logic [rrs_pkg::COORD_WIDTH-1:0]   span_x_right,
  output logic                              last_span
);

  localparam int CW = rrs_pkg::COORD_WIDTH;
  localparam int SW = rrs_pkg::STROKE_CNT_W;

  logic          cur_valid;
  logic [CW-1:0] cur_y;
  logic [CW-1:0] cur_a;
  logic [CW-1:0] cur_c;
  logic          cur_full;
  logic          cur_phase;
  logic [SW-1:0] cur_k;

  logic          cur_last;
  logic [CW-1:0] dx;

  // Last span of the row: final stroke step, right pixel or full span
  assign cur_last = (cur_k == cfg.count_last) && (cur_full || cur_phase);
  assign adv      = !cur_valid || cur_last;
  assign busy     = !adv;

  // Horizontal inset of the row
  assign dx = in_row.corner ? cfg.rad - in_root : '0;

  // Load a new row or step through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (adv) begin
      cur_valid <= in_valid;
      cur_y     <= in_row.y;
      cur_a     <= cfg.l + dx;
      cur_c     <= cfg.r - dx;
      cur_full  <= in_row.full;
      cur_phase <= 1'b0;
      cur_k     <= '0;
    end else if (cur_full || cur_phase) begin
      cur_k     <= cur_k + SW'(1);
      cur_a     <= cur_a + CW'(1);
      cur_c     <= cur_c - CW'(1);
      cur_phase <= 1'b0;
    end else begin
      cur_phase <= 1'b1;
    end
  end

  // Drive the span ports
  assign strobe       = cur_valid;
  assign span_y       = cur_y;
  assign span_x_left  = (cur_full || !cur_phase) ? cur_a : cur_c;
  assign span_x_right = (cur_full || cur_phase) ? cur_c : cur_a;
  assign last_span    = cur_valid && cur_last;

  // A row keeps the port until its last span
  a_row_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_span |=> strobe && (span_y == $past(span_y)))
    else $error("row ended before its last span");

  // Nothing more after a last span when no row is waiting
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    strobe && last_span && !in_valid |=> !strobe)
    else $error("span appeared without a row");

  // Outline pixels are one pixel wide
  a_pixel_span: assert property (@(posedge clk) disable iff (rst)
    strobe && !cur_full |-> span_x_left == span_x_right)
    else $error("outline pixel span is not one pixel");

endmodule
